// ===== hdl/gap_buffer_text_store_assert.svh =====
// assertion macros shared by the gap buffer modules
`ifndef GAP_BUFFER_TEXT_STORE_ASSERT_SVH
`define GAP_BUFFER_TEXT_STORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define GBTS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define GBTS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define GBTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gbts_pkg.sv =====
// shared constants and controller/datapath interface types for the gap buffer
package gbts_pkg;

  localparam int GBTS_CAPACITY = 1024;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_DEL_BACK  = 3'd1;
  localparam logic [2:0] OP_DEL_FWD   = 3'd2;
  localparam logic [2:0] OP_DEL_RANGE = 3'd3;
  localparam logic [2:0] OP_SET_CUR   = 3'd4;
  localparam logic [2:0] OP_MOVE_CUR  = 3'd5;
  localparam logic [2:0] OP_READ      = 3'd6;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic load;
    logic move_step;
    logic apply;
    logic rd_take;
    logic out_load;
  } gbts_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       range_ok;
    logic       read_ok;
    logic       at_target;
  } gbts_sts_t;

endpackage

// ===== hdl/gap_buffer_text_store.sv =====
// Gap buffer text store: a fixed-capacity byte text with a cursor, edited one command at a
// time through a single memory of CAPACITY bytes with one write and one registered read port.
// Edits (insert, delete back, delete forward, and a delete range whose range is valid) first
// move the gap to the edit point, copying one byte per cycle through that memory, so such a
// command runs longer the further the gap moves (zero when the edit lands where the last one
// left the gap, up to CAPACITY). A read inside the text passes through decode, two read
// states and finish; a cursor set or move, a refused read, a refused range and an unknown
// operation pass decode, apply and finish. A finished result waits in one output register: the
// next command is accepted while it is still there, but a command that finishes before it has
// left holds its own result, and the input, until the output stall drops.
// The text memory needs no clearing after reset; gap bytes are never read.
module gap_buffer_text_store
  import gbts_pkg::*;
#(
  parameter int CAPACITY = GBTS_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [7:0]         in_char_value,
  input  logic [10:0]        in_position,
  input  logic [10:0]        in_count,
  input  logic signed [11:0] in_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_read_byte,
  output logic [10:0]        out_cursor_pos,
  output logic [10:0]        out_text_length,
  output logic [1:0]         out_status
);

  gbts_cmd_t cmd;
  gbts_sts_t sts;

  gbts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbts_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_char_value   (in_char_value),
    .in_position     (in_position),
    .in_count        (in_count),
    .in_offset       (in_offset),
    .out_read_byte   (out_read_byte),
    .out_cursor_pos  (out_cursor_pos),
    .out_text_length (out_text_length),
    .out_status      (out_status)
  );

endmodule

// ===== hdl/gbts_datapath.sv =====
// gap buffer datapath: text memory, gap pointers, cursor and result registers
`include "gap_buffer_text_store_assert.svh"
module gbts_datapath
  import gbts_pkg::*;
#(
  parameter int CAPACITY = GBTS_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gbts_cmd_t          cmd,
  output gbts_sts_t          sts,
  input  logic [2:0]         in_operation,
  input  logic [7:0]         in_char_value,
  input  logic [10:0]        in_position,
  input  logic [10:0]        in_count,
  input  logic signed [11:0] in_offset,
  output logic [7:0]         out_read_byte,
  output logic [10:0]        out_cursor_pos,
  output logic [10:0]        out_text_length,
  output logic [1:0]         out_status
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = ((PW > 12) ? PW : 12) + 1;
  localparam int SW = EW + 1;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  logic [7:0] text_mem [CAPACITY];

  logic [PW-1:0] gs_r, gs_nxt;
  logic [PW-1:0] ge_r, ge_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] tgt_r;
  logic [2:0]    op_r;
  logic [7:0]    ch_r;
  logic [10:0]   pos_r;
  logic [10:0]   cnt_r;
  logic signed [11:0] off_r;
  logic          wv_r;
  logic [AW-1:0] wa_r;
  logic [7:0]    rd_data_r;
  logic [7:0]    rbyte_r;
  logic [1:0]    sts_r, sts_nxt;
  logic [7:0]    out_byte_r;
  logic [10:0]   out_cur_r;
  logic [10:0]   out_len_r;
  logic [1:0]    out_sts_r;

  logic [PW-1:0] len;
  logic [PW-1:0] gs_dec, ge_dec;
  logic [EW-1:0] len_e, pos_e, cnt_e, gs_e, ge_e, cur_e, phys_e, cur_adj_e, ge_sum_e;
  logic [EW-1:0] out_cur_e, out_len_e;
  logic signed [SW-1:0] mv_sum;
  logic          move_left, move_right;
  logic          full;
  logic          ins_we;
  logic [AW-1:0] raddr, waddr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  assign len    = CAP_P - (ge_r - gs_r);
  assign gs_dec = gs_r - 1'b1;
  assign ge_dec = ge_r - 1'b1;
  assign len_e  = EW'(len);
  assign pos_e  = EW'(pos_r);
  assign cnt_e  = EW'(cnt_r);
  assign gs_e   = EW'(gs_r);
  assign ge_e   = EW'(ge_r);
  assign cur_e  = EW'(cur_r);

  assign move_left  = tgt_r < gs_r;
  assign move_right = (tgt_r > gs_r) && (ge_r < CAP_P);
  assign full       = gs_r == ge_r;

  assign sts.op        = op_r;
  assign sts.range_ok  = (pos_e <= len_e) && (cnt_e <= len_e - pos_e);
  assign sts.read_ok   = pos_e < len_e;
  assign sts.at_target = !move_left && !move_right;

  // logical to physical address: skip over the gap
  assign phys_e = (pos_e < gs_e) ? pos_e : pos_e + (ge_e - gs_e);

  // gap move: left copies store[gs-1] to store[ge-1], right copies store[ge] to store[gs]
  assign raddr = cmd.move_step ? (move_left ? gs_dec[AW-1:0] : ge_r[AW-1:0])
                               : phys_e[AW-1:0];
  assign waddr = move_left ? ge_dec[AW-1:0] : gs_r[AW-1:0];

  assign ins_we = cmd.apply && (op_r == OP_INSERT) && !full;
  assign mem_we = wv_r || ins_we;
  assign mem_wa = wv_r ? wa_r : gs_r[AW-1:0];
  assign mem_wd = wv_r ? rd_data_r : ch_r;

  assign ge_sum_e  = ge_e + cnt_e;
  assign cur_adj_e = (cur_e - pos_e > cnt_e) ? cur_e - cnt_e : pos_e;
  assign mv_sum    = $signed({1'b0, cur_e}) + SW'(off_r);

  always_comb begin
    gs_nxt  = gs_r;
    ge_nxt  = ge_r;
    cur_nxt = cur_r;
    sts_nxt = sts_r;
    if (cmd.load) begin
      sts_nxt = ST_DONE;
    end
    if (cmd.move_step) begin
      if (move_left) begin
        gs_nxt = gs_dec;
        ge_nxt = ge_dec;
      end else begin
        gs_nxt = gs_r + 1'b1;
        ge_nxt = ge_r + 1'b1;
      end
    end
    if (cmd.apply) begin
      case (op_r)
        OP_INSERT: begin
          if (full) begin
            sts_nxt = ST_FULL;
          end else begin
            gs_nxt  = gs_r + 1'b1;
            cur_nxt = cur_r + 1'b1;
          end
        end
        OP_DEL_BACK: begin
          if (gs_r != '0) begin
            gs_nxt  = gs_dec;
            cur_nxt = cur_r - 1'b1;
          end
        end
        OP_DEL_FWD: begin
          if (ge_r != CAP_P) begin
            ge_nxt = ge_r + 1'b1;
          end
        end
        OP_DEL_RANGE: begin
          if (!sts.range_ok) begin
            sts_nxt = ST_INVALID;
          end else begin
            ge_nxt = ge_sum_e[PW-1:0];
            if (cur_e > pos_e) begin
              cur_nxt = cur_adj_e[PW-1:0];
            end
          end
        end
        OP_SET_CUR: begin
          cur_nxt = (pos_e > len_e) ? len : pos_e[PW-1:0];
        end
        OP_MOVE_CUR: begin
          if (mv_sum < 0) begin
            cur_nxt = '0;
          end else if (mv_sum > $signed({1'b0, len_e})) begin
            cur_nxt = len;
          end else begin
            cur_nxt = mv_sum[PW-1:0];
          end
        end
        default: begin
          // bad read or unknown operation
          sts_nxt = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r  <= '0;
      ge_r  <= CAP_P;
      cur_r <= '0;
      wv_r  <= 1'b0;
    end else begin
      gs_r  <= gs_nxt;
      ge_r  <= ge_nxt;
      cur_r <= cur_nxt;
      wv_r  <= cmd.move_step;
    end
  end

  always_ff @(posedge clk) begin
    wa_r  <= waddr;
    sts_r <= sts_nxt;
    if (cmd.load) begin
      op_r    <= in_operation;
      ch_r    <= in_char_value;
      pos_r   <= in_position;
      cnt_r   <= in_count;
      off_r   <= in_offset;
      rbyte_r <= '0;
      tgt_r   <= (in_operation == OP_DEL_RANGE) ? PW'(in_position) : cur_r;
    end else if (cmd.rd_take) begin
      rbyte_r <= rd_data_r;
    end
    if (cmd.out_load) begin
      out_byte_r <= rbyte_r;
      out_cur_r  <= out_cur_e[10:0];
      out_len_r  <= out_len_e[10:0];
      out_sts_r  <= sts_r;
    end
  end

  assign out_cur_e = EW'(cur_r);
  assign out_len_e = EW'(len);

  always_ff @(posedge clk) begin
    rd_data_r <= text_mem[raddr];
    if (mem_we) begin
      text_mem[mem_wa] <= mem_wd;
    end
  end

  assign out_read_byte   = out_byte_r;
  assign out_cursor_pos  = out_cur_r;
  assign out_text_length = out_len_r;
  assign out_status      = out_sts_r;

  `GBTS_ASSERT_ALWAYS(a_gap_order, gs_r <= ge_r, "gap start passed gap end")
  `GBTS_ASSERT_ALWAYS(a_gap_bound, ge_r <= CAP_P, "gap end beyond capacity")
  `GBTS_ASSERT_ALWAYS(a_cursor_bound, cur_r <= len, "cursor beyond text length")
  `GBTS_ASSERT_IMPLY(a_write_port, wv_r, !ins_we, "gap copy and insert share the write port")

endmodule

// ===== hdl/gbts_ctrl.sv =====
// gap buffer controller: command sequencing and result handshake
`include "gap_buffer_text_store_assert.svh"
module gbts_ctrl
  import gbts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  gbts_sts_t sts,
  output gbts_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_MOVE, S_DRAIN, S_APPLY, S_RD, S_RDW, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.op)
          OP_INSERT, OP_DEL_BACK, OP_DEL_FWD: state_nxt = S_MOVE;
          OP_DEL_RANGE: state_nxt = sts.range_ok ? S_MOVE : S_APPLY;
          OP_READ:      state_nxt = sts.read_ok ? S_RD : S_APPLY;
          default:      state_nxt = S_APPLY;
        endcase
      end
      S_MOVE: begin
        if (sts.at_target) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.move_step = 1'b1;
        end
      end
      // spare state between the settled gap and the edit
      S_DRAIN: state_nxt = S_APPLY;
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_FIN;
      end
      S_RD: state_nxt = S_RDW;
      S_RDW: begin
        cmd.rd_take = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `GBTS_ASSERT_IMPLY(a_move_edit_only, cmd.move_step,
    sts.op == OP_INSERT || sts.op == OP_DEL_BACK || sts.op == OP_DEL_FWD || sts.op == OP_DEL_RANGE,
    "gap moved for a command that does not edit")
  `GBTS_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid_r, "loaded result not presented")
  `GBTS_ASSERT_IMPLY(a_no_overwrite, cmd.out_load, !(out_valid_r && out_stall),
    "result register overwritten while stalled")

endmodule
